FILE: src/sat_pkg.sv
// Package: operation and status codes and shared types for the sorted array table.
`timescale 1ns / 1ps
package sat_pkg;

    typedef enum logic [3:0] {
        OP_READ_AT       = 4'd0,
        OP_SEARCH        = 4'd1,
        OP_SORTED_INSERT = 4'd2,
        OP_REMOVE        = 4'd3,
        OP_PUSH_FRONT    = 4'd4,
        OP_PUSH_BACK     = 4'd5,
        OP_INSERT_AT     = 4'd6,
        OP_POP_FRONT     = 4'd7,
        OP_POP_BACK      = 4'd8,
        OP_ERASE_AT      = 4'd9
    } op_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    localparam int OP_W     = 4;
    localparam int IN_KEY_W = 32;
    localparam int POS_W    = 6;
    localparam int STAT_W   = 3;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = 7;

    // Per-cell command, computed for each cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_SHUP  = 2'd1,
        CELL_SHDN  = 2'd2
    } cell_cmd_t;

endpackage

FILE: src/sat_if.sv
// Interfaces: input and result channels of the sorted array table.
`timescale 1ns / 1ps
interface sat_in_if;
    import sat_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [IN_KEY_W-1:0] key;
    logic [POS_W-1:0]    position;
    modport source (output valid, output operation, output key, output position, input ready);
    modport sink   (input valid, input operation, input key, input position, output ready);
endinterface

interface sat_out_if;
    import sat_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  found_index;
    logic [VAL_W-1:0]  value;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
    logic              is_full;
    modport source (output valid, output status, output found_index, output value,
                    output count, output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input found_index, input value,
                    input count, input is_empty, input is_full, output ready);
endinterface

FILE: src/sorted_array_table.sv
// Top level: sorted key table built as a chain of entry cells.
//
// Usage: operations arrive on in_ch (valid/ready); each produces exactly
// one result on out_ch. An operation is registered in the cycle it is
// accepted and decoded in the next, where the cells compare the key in
// parallel and a single shift of the whole chain commits an insert or
// removal once the output register is free. A new operation is taken
// only after the previous one has committed.
// The result sits in an output register; the next operation is taken
// while it waits, and processing stalls only when a second result is
// ready before the first one is taken.
// capacity_limit must be written through cfg_we/cfg_data while idle
// (not enforced by the block); values above DEPTH saturate to DEPTH.
// Reset clears the count (entries stay undefined until written; only
// entries below the count are ever read) and sets capacity to 64.
`timescale 1ns / 1ps
module sorted_array_table
    import sat_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    sat_in_if.sink           in_ch,
    sat_out_if.source        out_ch
);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]     cap_reg;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg;
    op_t                  op_reg;
    logic [OP_W-1:0]      op_raw_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [POS_W-1:0]     pos_reg;

    logic [KEY_WIDTH-1:0] keys [DEPTH];
    logic [DEPTH-1:0]     lt_v, le_v;
    logic [KEY_WIDTH-1:0] masked_key;

    assign masked_key = KEY_WIDTH >= IN_KEY_W ? KEY_WIDTH'(in_ch.key)
                                              : in_ch.key[KEY_WIDTH-1:0];

    logic [CW-1:0] cap_eff;
    assign cap_eff = (32'(cap_reg) > DEPTH) ? CW'(DEPTH) : CW'(cap_reg);

    // Output register
    logic              ov_reg;
    logic [STAT_W-1:0] st_reg;
    logic [POS_W-1:0]  idx_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CNT_W-1:0]  oc_reg;
    logic              oe_reg, of_reg;

    logic fire, commit;
    assign commit = busy_reg && (!ov_reg || out_ch.ready);
    assign in_ch.ready = !busy_reg;
    assign fire = in_ch.valid && in_ch.ready;

    // Lower/upper bound: first entry below the count whose compare fails
    // (the count itself when none does); the table need not be sorted.
    logic [CW-1:0] lb, ub;
    always_comb
    begin
        lb = cnt_reg;
        ub = cnt_reg;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (CW'(i) < cnt_reg && !lt_v[i]) lb = CW'(i);
            if (CW'(i) < cnt_reg && !le_v[i]) ub = CW'(i);
        end
    end

    logic [STAT_W-1:0] st_c;
    logic [CW-1:0]     idx_c;
    logic              ins_c, rem_c, full_c;
    logic [KEY_WIDTH-1:0] rd_c;
    always_comb
    begin
        st_c   = ST_OK;
        idx_c  = '0;
        ins_c  = 1'b0;
        rem_c  = 1'b0;
        full_c = cnt_reg >= cap_eff;
        case (op_raw_reg)
            OP_READ_AT, OP_ERASE_AT:
            begin
                if (cnt_reg == '0) st_c = ST_EMPTY;
                else if (CW'(pos_reg) >= cnt_reg || 32'(pos_reg) >= DEPTH) st_c = ST_RANGE;
                else begin idx_c = CW'(pos_reg); rem_c = (op_raw_reg == OP_ERASE_AT); end
            end
            OP_SEARCH, OP_REMOVE:
            begin
                if (lb >= cnt_reg || keys[lb[IW-1:0]] != key_reg) st_c = ST_NOT_FOUND;
                else begin idx_c = lb; rem_c = (op_raw_reg == OP_REMOVE); end
            end
            OP_SORTED_INSERT:
                if (full_c) st_c = ST_FULL; else begin idx_c = ub; ins_c = 1'b1; end
            OP_PUSH_FRONT:
                if (full_c) st_c = ST_FULL; else begin idx_c = '0; ins_c = 1'b1; end
            OP_PUSH_BACK:
                if (full_c) st_c = ST_FULL; else begin idx_c = cnt_reg; ins_c = 1'b1; end
            OP_INSERT_AT:
            begin
                if (full_c) st_c = ST_FULL;
                else if (CW'(pos_reg) > cnt_reg || 32'(pos_reg) > DEPTH) st_c = ST_RANGE;
                else begin idx_c = CW'(pos_reg); ins_c = 1'b1; end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (cnt_reg == '0) st_c = ST_EMPTY;
                else
                begin
                    idx_c = (op_raw_reg == OP_POP_FRONT) ? '0 : cnt_reg - CW'(1);
                    rem_c = 1'b1;
                end
            end
            default: ;
        endcase
        rd_c = keys[idx_c[IW-1:0]];
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ins_c) cnt_next = cnt_reg + CW'(1);
        else if (rem_c) cnt_next = cnt_reg - CW'(1);
    end

    // Chain of cells: each one shifts from its neighbor or loads the key.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            cell_cmd_t            cmd;
            logic [KEY_WIDTH-1:0] lk, rk;
            assign lk = (g == 0) ? key_reg : keys[(g == 0) ? 0 : g - 1];
            assign rk = (g == DEPTH - 1) ? keys[g] : keys[(g == DEPTH - 1) ? g : g + 1];
            always_comb
            begin
                cmd = CELL_HOLD;
                if (ins_c && CW'(g) > idx_c) cmd = CELL_SHUP;
                else if (rem_c && CW'(g) >= idx_c) cmd = CELL_SHDN;
            end
            sat_cell #(.KW(KEY_WIDTH)) u_cell (
                .clk      (clk),
                .shift_en (commit),
                .cmd      (cmd),
                .load     (ins_c && CW'(g) == idx_c),
                .load_key (key_reg),
                .left_key (lk),
                .right_key(rk),
                .cmp_key  (key_reg),
                .key_q    (keys[g]),
                .lt       (lt_v[g]),
                .le       (le_v[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CNT_W'(64);
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we) cap_reg <= cfg_data;
            if (fire) busy_reg <= 1'b1;
            else if (commit) busy_reg <= 1'b0;
            if (commit)
            begin
                cnt_reg <= cnt_next;
                ov_reg  <= 1'b1;
            end
            else if (out_ch.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            op_raw_reg <= in_ch.operation;
            op_reg     <= op_t'(in_ch.operation);
            key_reg    <= masked_key;
            pos_reg    <= in_ch.position;
        end
        if (commit)
        begin
            st_reg  <= st_c;
            idx_reg <= (st_c == ST_OK) ? POS_W'(idx_c) : '0;
            val_reg <= (st_c != ST_OK || op_reg > OP_ERASE_AT) ? '0
                     : (ins_c ? VAL_W'(key_reg) : VAL_W'(rd_c));
            oc_reg  <= CNT_W'(cnt_next);
            oe_reg  <= cnt_next == '0;
            of_reg  <= cnt_next >= cap_eff;
        end
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.status      = st_reg;
    assign out_ch.found_index = idx_reg;
    assign out_ch.value       = val_reg;
    assign out_ch.count       = oc_reg;
    assign out_ch.is_empty    = oe_reg;
    assign out_ch.is_full     = of_reg;
endmodule

FILE: src/sat_cell.sv
// Cell: one table entry with its key compares and neighbor shift.
`timescale 1ns / 1ps
module sat_cell
    import sat_pkg::*;
#(
    parameter int KW = 32
) (
    input  logic          clk,
    input  logic          shift_en,
    input  cell_cmd_t     cmd,
    input  logic          load,
    input  logic [KW-1:0] load_key,
    input  logic [KW-1:0] left_key,
    input  logic [KW-1:0] right_key,
    input  logic [KW-1:0] cmp_key,
    output logic [KW-1:0] key_q,
    output logic          lt,
    output logic          le
);
    logic [KW-1:0] key_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            if (load)
                key_reg <= load_key;
            else
            begin
                case (cmd)
                    CELL_SHUP: key_reg <= left_key;
                    CELL_SHDN: key_reg <= right_key;
                    default:   key_reg <= key_reg;
                endcase
            end
        end
    end

    assign key_q = key_reg;
    assign lt    = key_reg < cmp_key;
    assign le    = key_reg <= cmp_key;
endmodule

FILE: src/sat_checker.sv
// Checker: port-level properties of the sorted array table, bound to the top level.
`timescale 1ns / 1ps
module sat_checker
    import sat_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [STAT_W-1:0] status,
    input logic [POS_W-1:0]  found_index,
    input logic [CNT_W-1:0]  count,
    input logic             is_empty
);
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (count == '0)))
        else $error("empty flag disagrees with count");
    a_err_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> found_index == '0)
        else $error("error result carries an index");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(count))
        else $error("stalled result changed");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transfer taken during work");
endmodule

bind sorted_array_table sat_checker u_sat_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .status     (out_ch.status),
    .found_index(out_ch.found_index),
    .count      (out_ch.count),
    .is_empty   (out_ch.is_empty)
);
